[src/trf_pkg.sv]
`timescale 1ns / 1ps

package trf_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int POS_W      = $clog2(RING_DEPTH);
   localparam int SIZE_W     = POS_W + 1;
   localparam int BSIZE_W    = 11;
   localparam int CMP_W      = (SIZE_W > BSIZE_W) ? SIZE_W : BSIZE_W;
   localparam int FILL_W     = 11;
   localparam logic [FILL_W-1:0] FILL_MAX = '1;
   localparam int CSR_AW     = 4;

   localparam logic [BSIZE_W-1:0] BUFFER_SIZE_RST = 11'd1024;
   localparam logic [7:0]         FRAME_BYTE_RST  = 8'd126;
   localparam logic [7:0]         ESCAPE_BYTE_RST = 8'd125;
   localparam logic [7:0]         ESCAPE_XOR_RST  = 8'd32;

   typedef enum logic [2:0] {
      CMD_BEGIN   = 3'd0,
      CMD_DATA    = 3'd1,
      CMD_RAW_SUM = 3'd2,
      CMD_RAW     = 3'd3,
      CMD_END     = 3'd4,
      CMD_READ    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      REG_BUFFER_SIZE = 2'd0,
      REG_FRAME_BYTE  = 2'd1,
      REG_ESCAPE_BYTE = 2'd2,
      REG_ESCAPE_XOR  = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [BSIZE_W-1:0] buffer_size;
      logic [7:0]         frame_byte;
      logic [7:0]         escape_byte;
      logic [7:0]         escape_xor;
   } cfg_type;

   typedef struct packed {
      logic             we;
      logic [POS_W-1:0] waddr;
      logic [7:0]       wdata;
      logic             re;
      logic [POS_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] val;
   } stuff_type;

   // byte stuffing: flag or escape byte goes out xored, behind an escape byte
   function automatic stuff_type stuff(input logic [7:0] b, input cfg_type cfg);
      stuff_type r;
      r.hit = (b == cfg.frame_byte) || (b == cfg.escape_byte);
      r.val = r.hit ? (b ^ cfg.escape_xor) : b;
      return r;
   endfunction

endpackage

[src/trf_ring_ram.sv]
`timescale 1ns / 1ps

module trf_ring_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/trf_seq.sv]
`timescale 1ns / 1ps

module trf_seq import trf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tuser,
   output ram_req_type ram_req,
   input  logic [7:0]  ram_rdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WRITE = 5'b00010,
      S_CHECK = 5'b00100,
      S_READ  = 5'b01000,
      S_RDATA = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        seq_ff, seq_in, sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic [7:0]        q_ff [4];
   logic [7:0]        q_in [4];
   logic [2:0]        cnt_ff, cnt_in;
   logic              end_ff, end_in;

   logic [SIZE_W-1:0] eff_size, wp_inc, rp_inc;
   logic [POS_W-1:0]  wp_next, rp_next;
   logic [CMP_W-1:0]  bs_ext;
   logic              accept;
   logic [7:0]        seq_inc, chk;
   stuff_type         st_a, st_b;
   logic [7:0]        cand_byte [4];
   logic [3:0]        cand_vld;
   logic [7:0]        pack [4];
   logic [2:0]        n;

   // out-of-range size means the whole ring
   always_comb begin
      bs_ext = CMP_W'(cfg.buffer_size);
      if (bs_ext == '0 || bs_ext > CMP_W'(RING_DEPTH)) begin
         eff_size = SIZE_W'(RING_DEPTH);
      end else begin
         eff_size = SIZE_W'(cfg.buffer_size);
      end
   end

   assign wp_inc  = {1'b0, wp_ff} + SIZE_W'(1);
   assign rp_inc  = {1'b0, rp_ff} + SIZE_W'(1);
   assign wp_next = (wp_inc >= eff_size) ? '0 : wp_inc[POS_W-1:0];
   assign rp_next = (rp_inc >= eff_size) ? '0 : rp_inc[POS_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign seq_inc    = seq_ff + 8'd1;
   assign chk        = ~sum_ff;

   // byte list of one item, at most four
   always_comb begin
      st_a     = stuff(req_tdata, cfg);
      st_b     = stuff(req_tdata, cfg);
      cand_vld = '0;
      for (int i = 0; i < 4; i++) begin
         cand_byte[i] = cfg.escape_byte;
      end
      unique case (req_tuser)
         CMD_BEGIN: begin
            st_a         = stuff(seq_inc, cfg);
            cand_vld     = {1'b1, st_b.hit, 1'b1, st_a.hit};
            cand_byte[1] = st_a.val;
            cand_byte[3] = st_b.val;
         end
         CMD_DATA: begin
            cand_vld     = {2'b00, 1'b1, st_a.hit};
            cand_byte[1] = st_a.val;
         end
         CMD_RAW_SUM, CMD_RAW: begin
            cand_vld     = 4'b0010;
            cand_byte[1] = req_tdata;
         end
         CMD_END: begin
            st_a         = stuff(chk, cfg);
            cand_vld     = {1'b1, 1'b0, 1'b1, st_a.hit};
            cand_byte[1] = st_a.val;
            cand_byte[3] = cfg.frame_byte;
         end
         default: begin
            cand_vld = '0;
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         pack[i] = '0;
      end
      n = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_vld[i]) begin
            pack[n[1:0]] = cand_byte[i];
            n            = n + 3'd1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      seq_in       = seq_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_empty_in = rsp_empty_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      ram_req      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               q_in   = pack;
               cnt_in = n;
               end_in = (req_tuser == CMD_END);
               unique case (req_tuser)
                  CMD_BEGIN: begin
                     seq_in   = seq_inc;
                     sum_in   = seq_inc + req_tdata;
                     state_in = S_WRITE;
                  end
                  CMD_DATA, CMD_RAW_SUM: begin
                     sum_in   = sum_ff + req_tdata;
                     state_in = S_WRITE;
                  end
                  CMD_RAW: begin
                     state_in = S_WRITE;
                  end
                  CMD_END: begin
                     sum_in   = st_a.val;
                     state_in = S_WRITE;
                  end
                  CMD_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WRITE: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = wp_ff;
            ram_req.wdata = q_ff[0];
            wp_in         = wp_next;
            fill_in       = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + FILL_W'(1);
            q_in[0]       = q_ff[1];
            q_in[1]       = q_ff[2];
            q_in[2]       = q_ff[3];
            cnt_in        = cnt_ff - 3'd1;
            if (cnt_ff == 3'd1) begin
               state_in = end_ff ? S_CHECK : S_IDLE;
            end
         end
         S_CHECK: begin
            // overrun: drop the oldest data
            if (CMP_W'(fill_ff) > CMP_W'(eff_size)) begin
               rp_in   = wp_ff;
               fill_in = FILL_W'(eff_size);
            end
            state_in = S_IDLE;
         end
         S_READ: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (fill_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = '0;
                  rsp_empty_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = rp_ff;
                  state_in      = S_RDATA;
               end
            end
         end
         S_RDATA: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = ram_rdata;
            rsp_empty_in = 1'b0;
            rp_in        = rp_next;
            fill_in      = fill_ff - FILL_W'(1);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         seq_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         end_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         seq_ff       <= seq_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         end_ff       <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_empty_ff <= rsp_empty_in;
      q_ff         <= q_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule

[src/trace_record_framer_ring_core.sv]
`timescale 1ns / 1ps
// items: a begin is written to the ring as 2 to 4 bytes, data commands 1 to 2, raw ones 1,
// end 2 to 3 and then an overrun check; a read result comes from a registered ring read (an
// empty marker on an empty ring), and waits while an earlier result beat is still held
// throughput: one item at a time, bound by the single write port of the ring memory
// (one stuffed byte per cycle); no new request is taken until the last item is through
// reset: synchronous, clears pointers, fill count, sequence, checksum and the result beat,
// and loads the register defaults; ring contents are left as they are

module trace_record_framer_ring_core import trf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic [2:0]        req_tuser,   // [2:0] command
   // response stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] read_byte
   output logic              rsp_tuser,   // [0] empty_res
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   ram_req_type ram_req;
   logic [7:0]  ram_rdata;
   logic        csr_wr;

   // register file: a write lands on the access cycle
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_BUFFER_SIZE: cfg_in.buffer_size = csr_pwdata[BSIZE_W-1:0];
            REG_FRAME_BYTE:  cfg_in.frame_byte  = csr_pwdata[7:0];
            REG_ESCAPE_BYTE: cfg_in.escape_byte = csr_pwdata[7:0];
            REG_ESCAPE_XOR:  cfg_in.escape_xor  = csr_pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BUFFER_SIZE: csr_prdata = 32'(cfg_ff.buffer_size);
         REG_FRAME_BYTE:  csr_prdata = 32'(cfg_ff.frame_byte);
         REG_ESCAPE_BYTE: csr_prdata = 32'(cfg_ff.escape_byte);
         REG_ESCAPE_XOR:  csr_prdata = 32'(cfg_ff.escape_xor);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_size <= BUFFER_SIZE_RST;
         cfg_ff.frame_byte  <= FRAME_BYTE_RST;
         cfg_ff.escape_byte <= ESCAPE_BYTE_RST;
         cfg_ff.escape_xor  <= ESCAPE_XOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: stuffs one item into a byte list and writes it one byte a cycle
   trf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata)
   );

   // byte ring, one write and one registered read port
   trf_ring_ram #(
      .DEPTH  (RING_DEPTH),
      .DATA_W (8)
   ) u_ring (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

endmodule

[src/trf_checker.sv]
`timescale 1ns / 1ps

module trf_checker import trf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [7:0]        req_tdata,
   input logic [2:0]        req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [7:0]        rsp_tdata,
   input logic              rsp_tuser,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [CSR_AW-1:0] csr_paddr,
   input logic [31:0]       csr_pwdata,
   input logic [31:0]       csr_prdata,
   input logic              csr_pready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // an empty marker carries a zero byte
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("empty result with non-zero byte");

   // no result beat straight out of reset
   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result beat after reset");

   // a result never appears the cycle right after an accepted request
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result beat too early");

endmodule

bind trace_record_framer_ring_core trf_checker u_trf_checker (.*);
